// File: src/cfb_pkg.sv
package cfb_pkg;

    // frame constants
    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] FTR_BYTE     = 8'hAA;
    localparam logic [7:0] FMT_WIDE_LEN = 8'h10;
    localparam logic [8:0] BASE_LEN     = 9'd5;

    // item kinds carried on the input tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // most bytes one item can cause, and the count width
    localparam int BURST_MAX = 5;
    localparam int CNT_W     = 3;

    // bytes caused by one accepted item
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_footer;
    } t_burst;

endpackage

// File: src/cfb_encode.sv
module cfb_encode
    import cfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_cmd_id,
    input  logic [3:0] i_query_len,
    input  logic [7:0] i_payload_len,
    input  logic [7:0] i_data_byte,
    output t_burst     o_burst
);

    logic       r_frame_open;
    logic [8:0] r_bytes_remaining;
    logic       n_frame_open;
    logic [8:0] n_bytes_remaining;

    logic [8:0] body_len;
    logic [8:0] total_len;
    logic [8:0] total_wide;
    logic       wide;

    // frame length arithmetic
    assign body_len   = {5'd0, i_query_len} + {1'b0, i_payload_len};
    assign total_len  = BASE_LEN + body_len;
    assign wide       = total_len > 9'd255;
    assign total_wide = total_len + 9'd1;

    // byte list and next state for the item on the input
    always_comb begin
        o_burst           = '0;
        n_frame_open      = r_frame_open;
        n_bytes_remaining = r_bytes_remaining;
        case (i_op)
            OP_START: begin
                o_burst.bytes[0] = HDR_BYTE;
                o_burst.bytes[1] = i_cmd_id;
                if (wide) begin
                    o_burst.bytes[2] = FMT_WIDE_LEN | {4'd0, i_query_len};
                    o_burst.bytes[3] = {7'd0, total_wide[8]};
                    o_burst.bytes[4] = total_wide[7:0];
                    o_burst.count    = CNT_W'(5);
                end else begin
                    o_burst.bytes[2] = {4'd0, i_query_len};
                    o_burst.bytes[3] = total_len[7:0];
                    o_burst.count    = CNT_W'(4);
                end
                n_bytes_remaining = body_len;
                if (body_len == 9'd0) begin
                    // empty frame closes at once
                    o_burst.bytes[4]   = FTR_BYTE;
                    o_burst.count      = CNT_W'(5);
                    o_burst.has_footer = 1'b1;
                    n_frame_open       = 1'b0;
                end else begin
                    n_frame_open = 1'b1;
                end
            end
            OP_DATA: begin
                if (r_frame_open) begin
                    o_burst.bytes[0] = i_data_byte;
                    o_burst.count    = CNT_W'(1);
                    if (r_bytes_remaining != 9'd0) begin
                        n_bytes_remaining = r_bytes_remaining - 9'd1;
                    end
                    if (r_bytes_remaining <= 9'd1) begin
                        o_burst.bytes[1]   = FTR_BYTE;
                        o_burst.count      = CNT_W'(2);
                        o_burst.has_footer = 1'b1;
                        n_frame_open       = 1'b0;
                    end
                end
            end
            default: begin
                o_burst = '0;
            end
        endcase
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open      <= 1'b0;
            r_bytes_remaining <= 9'd0;
        end else if (i_accept) begin
            r_frame_open      <= n_frame_open;
            r_bytes_remaining <= n_bytes_remaining;
        end
    end

endmodule

// File: src/cfb_serializer.sv
module cfb_serializer
    import cfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_footer
);

    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_last_idx;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_has_footer;
    logic                      r_valid;
    logic                      take;

    assign take     = r_valid & i_ready;
    assign o_valid  = r_valid;
    assign o_last   = (r_idx == r_last_idx);
    assign o_footer = o_last & r_has_footer;
    assign o_byte   = r_bytes[r_idx];
    // room for a new list when none is held or once the current last beat leaves
    assign o_free   = !r_valid || (take && o_last);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && (i_burst.count != '0)) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && o_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && (i_burst.count != '0)) begin
            r_bytes      <= i_burst.bytes;
            r_last_idx   <= i_burst.count - CNT_W'(1);
            r_has_footer <= i_burst.has_footer;
        end
    end

endmodule

// File: src/command_frame_builder.sv
// Display-command frame builder. Each beat on the slave side is a start item
// (tuser = 0: command id, query length, payload length) or a data item
// (tuser = 1: one query or payload byte). A start item yields the header
// 0xFF, the command id, the format byte and a one- or two-byte length
// (two bytes, big-endian, when the frame would exceed 255 bytes), plus the
// footer 0xAA when both lengths are zero; a data item yields its byte and,
// after the last one of the frame, the footer. Data with no open frame is
// dropped; a new start abandons an open frame without a footer. The master
// side carries one byte per beat, tlast on the last byte caused by an item
// and tuser on the footer. An item holds the input until all beats it yields
// have left (one for a data byte, two for the last one, four or five for a
// start, none for a dropped item); the single output byte register sets this,
// and the next item is taken in the cycle the previous item's last beat leaves,
// so data bytes stream at one per cycle while m_axis_tready is held high.
module command_frame_builder
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd_id[7:0], query_len[11:8], payload_len[19:12], data_byte[27:20], zero pad
    input  logic [31:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // frame_end[0]
    output logic        m_axis_tuser
);

    t_burst burst;
    logic   free;
    logic   accept;

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid & free;

    // decode item and track frame state
    cfb_encode u_encode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (s_axis_tuser),
        .i_cmd_id      (s_axis_tdata[7:0]),
        .i_query_len   (s_axis_tdata[11:8]),
        .i_payload_len (s_axis_tdata[19:12]),
        .i_data_byte   (s_axis_tdata[27:20]),
        .o_burst       (burst)
    );

    // emit the byte list one beat at a time
    cfb_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_burst  (burst),
        .o_free   (free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_footer (m_axis_tuser)
    );

endmodule

// File: src/cfb_checker.sv
module cfb_checker
    import cfb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // no output beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // footer is always the last beat of its item
    a_footer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("footer not marked last");

    // footer carries the footer byte
    a_footer_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == FTR_BYTE))
        else $error("footer byte wrong");

    // input is held off while an item still has beats to go
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken mid item");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled beat changed");

endmodule

bind command_frame_builder cfb_checker u_cfb_checker (.*);
